### sv/wfu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfu_pkg
// Shared types and constants for the websocket frame unmasker.
// ----------------------------------------------------------------------------
package wfu_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [3:0] OPCODE_CLOSE = 4'h8;
   localparam logic [6:0] LEN7_EXT16   = 7'd126;
   localparam logic [6:0] LEN7_EXT64   = 7'd127;
   localparam logic [3:0] EXT16_BYTES  = 4'd2;
   localparam logic [3:0] EXT64_BYTES  = 4'd8;
   localparam logic [3:0] KEY_BYTES    = 4'd4;

   typedef struct packed {
      logic [7:0] data;
      logic [7:0] key;
      logic [3:0] opcode;
      logic       last;
      logic       empty;
   } wfu_entry_type;

   typedef struct packed {
      logic          valid;
      wfu_entry_type entry;
   } wfu_push_type;

   typedef struct packed {
      logic          valid;
      wfu_entry_type entry;
   } wfu_head_type;

endpackage
`default_nettype wire

### sv/wfu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfu_front
// Header parser: tracks the frame phase, collects length and mask key and
// pushes one queue entry per payload byte or empty-frame marker.
// ----------------------------------------------------------------------------
module wfu_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               byte_accept,
   input  wire logic [7:0]         rx_byte,
   output wfu_pkg::wfu_push_type   push
);
   import wfu_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR1 = 3'd0,
      PH_HDR2 = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic [3:0]   opcode_ff, opcode_in;
   logic [63:0]  remain_ff, remain_in;
   logic [3:0]   left_ff, left_in;
   logic [31:0]  key_ff, key_in;
   logic [1:0]   pos_ff, pos_in;
   logic [7:0]   key_byte;
   logic [3:0]   left_dec;
   logic [63:0]  remain_dec;

   assign left_dec   = left_ff - 4'd1;
   assign remain_dec = remain_ff - 64'd1;

   always_comb begin
      case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      remain_in = remain_ff;
      left_in   = left_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      push      = '0;
      push.entry.opcode = opcode_ff;
      if (byte_accept) begin
         unique case (phase_ff)
            PH_HDR2: begin
               remain_in = '0;
               key_in    = '0;
               pos_in    = '0;
               if (rx_byte[6:0] == LEN7_EXT16) begin
                  left_in  = EXT16_BYTES;
                  phase_in = PH_EXT;
               end else if (rx_byte[6:0] == LEN7_EXT64) begin
                  left_in  = EXT64_BYTES;
                  phase_in = PH_EXT;
               end else begin
                  remain_in = {57'd0, rx_byte[6:0]};
                  left_in   = KEY_BYTES;
                  phase_in  = PH_MASK;
               end
            end
            PH_EXT: begin
               remain_in = {remain_ff[55:0], rx_byte};
               left_in   = left_dec;
               if (left_dec == 4'd0) begin
                  left_in  = KEY_BYTES;
                  phase_in = PH_MASK;
               end
            end
            PH_MASK: begin
               key_in  = {key_ff[23:0], rx_byte};
               left_in = left_dec;
               if (left_dec == 4'd0) begin
                  pos_in = '0;
                  if (remain_ff == 64'd0) begin
                     phase_in         = PH_HDR1;
                     push.valid       = 1'b1;
                     push.entry.last  = 1'b1;
                     push.entry.empty = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               pos_in    = pos_ff + 2'd1;
               remain_in = remain_dec;
               push.valid      = 1'b1;
               push.entry.data = rx_byte;
               push.entry.key  = key_byte;
               push.entry.last = (remain_dec == 64'd0);
               if (remain_dec == 64'd0) begin
                  phase_in = PH_HDR1;
               end
            end
            default: begin
               opcode_in = rx_byte[3:0];
               left_in   = '0;
               phase_in  = PH_HDR2;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR1;
         opcode_ff <= '0;
         remain_ff <= '0;
         left_ff   <= '0;
         key_ff    <= '0;
         pos_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         remain_ff <= remain_in;
         left_ff   <= left_in;
         key_ff    <= key_in;
         pos_ff    <= pos_in;
      end
   end

   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> remain_ff != 64'd0)
      else $error("payload phase with zero remaining length");

   a_marker_on_key_end: assert property (@(posedge clock) disable iff (reset)
      push.valid && push.entry.empty |-> phase_ff == PH_MASK && left_ff == 4'd1)
      else $error("empty marker outside last key byte");

endmodule
`default_nettype wire

### sv/wfu_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfu_queue
// Short FIFO between the header parser and the output stage.
// ----------------------------------------------------------------------------
module wfu_queue #(
   parameter int DEPTH = wfu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wfu_pkg::wfu_push_type push,
   input  wire logic             pop,
   output wfu_pkg::wfu_head_type head,
   output logic                  full
);
   import wfu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wfu_entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;

   assign full          = (count_ff == CNT_W'(DEPTH));
   assign head.valid    = (count_ff != '0);
   assign head.entry    = mem_ff[rd_ptr_ff];
   assign do_push       = push.valid && !full;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("entry pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

### sv/wfu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wfu_back
// Output stage: unmasks the queued byte and holds the result transfer.
// ----------------------------------------------------------------------------
module wfu_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wfu_pkg::wfu_head_type head,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast,
   output logic [5:0]            rsp_tuser
);
   import wfu_pkg::*;

   logic       valid_ff;
   logic [7:0] data_ff;
   logic [3:0] opcode_ff;
   logic       close_ff;
   logic       last_ff;
   logic       empty_ff;

   assign pop = head.valid && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff   <= head.entry.data ^ head.entry.key;
         opcode_ff <= head.entry.opcode;
         close_ff  <= (head.entry.opcode == OPCODE_CLOSE);
         last_ff   <= head.entry.last;
         empty_ff  <= head.entry.empty;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = {empty_ff, close_ff, opcode_ff};

endmodule
`default_nettype wire

### sv/websocket_frame_unmasker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// websocket_frame_unmasker
// Client-to-server websocket frame parser and payload unmasker.
//
// req channel: one received stream byte per transfer on req_tdata.
// rsp channel: one unmasked payload byte per transfer, or one marker for
// a frame with no payload (tdata zero, empty flag set in tuser).
// rsp_tlast marks the final byte of a frame and the empty-frame marker.
// Header, length and mask-key bytes give no output transfer.
// Throughput: one byte per cycle while the queue is not full; the parser keeps one byte-wide register
// path per cycle and the 64-bit length count sets the longest path.
// A payload byte is written to the queue in the same cycle that it is accepted
// and is offered on rsp from the output register that follows the queue.
// Reset clears the parser to expect a first header byte and empties the
// queue. When the receiver stalls, the queue fills and req_tready drops
// once it is full; nothing is lost.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker #(
   parameter int QUEUE_DEPTH = wfu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] payload_byte
   output logic            rsp_tlast,
   output logic [5:0]      rsp_tuser    // [3:0] frame_opcode, [4] close_frame, [5] empty_frame
);
   import wfu_pkg::*;

   wfu_push_type push;
   wfu_head_type head;
   logic         full;
   logic         pop;
   logic         byte_accept;

   assign req_tready  = !full;
   assign byte_accept = req_tvalid && req_tready;

   wfu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .push        (push)
   );

   wfu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   wfu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench for the websocket frame unmasker. A byte-level tracker
// of the frame parser predicts every unmasked byte and empty-frame marker;
// each rsp transfer is checked field by field in order. Directed frames cover
// every opcode, the three length encodings, empty and close frames and the
// flag bits; random frames follow with idle and stall bursts on both sides,
// then a gap-free stretch and a frame whose 64-bit length has its top bit set.
// ----------------------------------------------------------------------------
module tb_top;
   import wfu_pkg::*;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LENGTH,
      PH_EXT_LEN,
      PH_KEY,
      PH_PAYLOAD
   } parse_phase_type;

   typedef enum int {
      LEN_SHORT,
      LEN_EXT16,
      LEN_EXT64
   } len_form_type;

   typedef struct packed {
      logic [7:0] payload;
      logic [3:0] opcode;
      logic       close;
      logic       last;
      logic       empty;
   } frame_result_type;

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;    // [7:0] rx_byte
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;    // [7:0] payload_byte
   logic       rsp_tlast;
   logic [5:0] rsp_tuser;    // [3:0] frame_opcode, [4] close_frame, [5] empty_frame

   frame_result_type frame_results_due[$];
   int               error_count = 0;
   int               bytes_sent  = 0;
   bit               idling_on   = 1'b1;

   // tracker copy of the parser state
   parse_phase_type trk_phase      = PH_HEADER;
   logic [3:0]      trk_opcode     = '0;
   logic [63:0]     trk_remaining  = '0;
   logic [3:0]      trk_count_left = '0;
   logic [31:0]     trk_key        = '0;
   logic [1:0]      trk_key_index  = '0;

   websocket_frame_unmasker u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #16_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic frame_result_type make_result(input logic [7:0] value, input logic last,
                                                    input logic empty);
      frame_result_type r;
      r.payload = value;
      r.opcode  = trk_opcode;
      r.close   = (trk_opcode == OPCODE_CLOSE);
      r.last    = last;
      r.empty   = empty;
      return r;
   endfunction

   task automatic track_frame_byte(input logic [7:0] value);
      logic [7:0] key_byte;
      case (trk_phase)
         PH_LENGTH: begin
            trk_remaining = '0;
            trk_key       = '0;
            trk_key_index = '0;
            if (value[6:0] == LEN7_EXT16) begin
               trk_count_left = EXT16_BYTES;
               trk_phase      = PH_EXT_LEN;
            end else if (value[6:0] == LEN7_EXT64) begin
               trk_count_left = EXT64_BYTES;
               trk_phase      = PH_EXT_LEN;
            end else begin
               trk_remaining  = {57'd0, value[6:0]};
               trk_count_left = KEY_BYTES;
               trk_phase      = PH_KEY;
            end
         end
         PH_EXT_LEN: begin
            trk_remaining  = {trk_remaining[55:0], value};
            trk_count_left = trk_count_left - 4'd1;
            if (trk_count_left == 4'd0) begin
               trk_count_left = KEY_BYTES;
               trk_phase      = PH_KEY;
            end
         end
         PH_KEY: begin
            trk_key        = {trk_key[23:0], value};
            trk_count_left = trk_count_left - 4'd1;
            if (trk_count_left == 4'd0) begin
               trk_key_index = '0;
               if (trk_remaining == 64'd0) begin
                  trk_phase = PH_HEADER;
                  frame_results_due.push_back(make_result(8'h00, 1'b1, 1'b1));
               end else begin
                  trk_phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            key_byte      = trk_key[8 * (3 - trk_key_index) +: 8];
            trk_key_index = trk_key_index + 2'd1;
            trk_remaining = trk_remaining - 64'd1;
            if (trk_remaining == 64'd0) begin
               trk_phase = PH_HEADER;
            end
            frame_results_due.push_back(make_result(value ^ key_byte,
                                                    trk_remaining == 64'd0, 1'b0));
         end
         default: begin
            trk_opcode     = value[3:0];
            trk_count_left = '0;
            trk_phase      = PH_LENGTH;
         end
      endcase
   endtask

   // called at a falling edge, returns at a falling edge with req_tvalid still high
   task automatic send_byte(input logic [7:0] value);
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      do @(posedge clock); while (!req_tready);
      track_frame_byte(value);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] header, input bit mask_flag,
                             input len_form_type form, input logic [63:0] length,
                             input logic [31:0] key, input int fill, input int payload_count);
      logic [7:0] data_byte;
      send_byte(header);
      case (form)
         LEN_SHORT: begin
            send_byte({mask_flag, length[6:0]});
         end
         LEN_EXT16: begin
            send_byte({mask_flag, LEN7_EXT16});
            send_byte(length[15:8]);
            send_byte(length[7:0]);
         end
         default: begin
            send_byte({mask_flag, LEN7_EXT64});
            for (int i = 7; i >= 0; i--) send_byte(length[8 * i +: 8]);
         end
      endcase
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
      for (int i = 0; i < payload_count; i++) begin
         data_byte = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
         send_byte(data_byte);
      end
   endtask

   task automatic send_random_frame();
      int           pick;
      int           length;
      len_form_type form;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         length = 0;
         form   = LEN_SHORT;
      end else if (pick <= 10) begin
         length = $urandom_range(1, 16);
         form   = LEN_SHORT;
      end else if (pick == 11) begin
         length = $urandom_range(17, 125);
         form   = LEN_SHORT;
      end else if (pick <= 13) begin
         length = $urandom_range(0, 300);
         form   = LEN_EXT16;
      end else begin
         length = $urandom_range(0, 300);
         form   = LEN_EXT64;
      end
      send_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, 64'(length),
                 $urandom(), -1, length);
   endtask

   task automatic wait_drained();
      int n;
      n = 0;
      while (frame_results_due.size() != 0 && n < 20000) begin
         @(negedge clock);
         n++;
      end
   endtask

   task automatic test_directed_frames();
      send_frame(8'h81, 1'b1, LEN_SHORT, 64'd0, 32'h1234_5678, -1, 0);
      send_frame(8'h88, 1'b1, LEN_SHORT, 64'd0, 32'hA5A5_5A5A, -1, 0);
      send_frame(8'h00, 1'b0, LEN_SHORT, 64'd1, 32'hFFFF_FFFF, 8'h00, 1);
      send_frame(8'hFF, 1'b1, LEN_SHORT, 64'd5, 32'h0000_0000, 8'hFF, 5);
      send_frame(8'h08, 1'b1, LEN_SHORT, 64'd3, $urandom(), -1, 3);
      send_frame(8'h82, 1'b1, LEN_SHORT, 64'd125, $urandom(), -1, 125);
      send_frame(8'h81, 1'b1, LEN_EXT16, 64'd0, $urandom(), -1, 0);
      send_frame(8'h82, 1'b1, LEN_EXT16, 64'd2, $urandom(), -1, 2);
      send_frame(8'h82, 1'b1, LEN_EXT16, 64'h0103, $urandom(), -1, 259);
      send_frame(8'h88, 1'b1, LEN_EXT64, 64'd0, $urandom(), -1, 0);
      send_frame(8'h82, 1'b0, LEN_EXT64, 64'h0107, $urandom(), -1, 263);
      for (int op = 0; op < 16; op++) begin
         send_frame({4'($urandom_range(0, 15)), 4'(op)}, 1'b1, LEN_SHORT, 64'd1,
                    $urandom(), -1, 1);
      end
   endtask

   task automatic test_random_frames();
      int  start_count;
      bit  drained_once;
      start_count  = bytes_sent;
      drained_once = 1'b0;
      while (bytes_sent < start_count + 600) begin
         send_random_frame();
         if (!drained_once && bytes_sent > start_count + 300) begin
            req_tvalid = 1'b0;
            wait_drained();
            drained_once = 1'b1;
         end
      end
   endtask

   task automatic test_back_to_back();
      int start_count;
      idling_on   = 1'b0;
      start_count = bytes_sent;
      while (bytes_sent < start_count + 300) send_random_frame();
   endtask

   task automatic test_top_bit_length();
      send_frame(8'($urandom_range(0, 255)), 1'b1, LEN_EXT64,
                 {1'b1, 31'($urandom()), 32'($urandom())}, $urandom(), -1, 40);
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 9) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (frame_results_due.size() == 0) begin
            $error("unexpected transfer: payload_byte %0h", rsp_tdata);
            error_count++;
         end else begin
            want = frame_results_due.pop_front();
            if (rsp_tdata !== want.payload) begin
               $error("payload_byte: expected %0h, got %0h", want.payload, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[3:0] !== want.opcode) begin
               $error("frame_opcode: expected %0h, got %0h", want.opcode, rsp_tuser[3:0]);
               error_count++;
            end
            if (rsp_tuser[4] !== want.close) begin
               $error("close_frame: expected %0b, got %0b", want.close, rsp_tuser[4]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_in_frame: expected %0b, got %0b", want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser[5] !== want.empty) begin
               $error("empty_frame: expected %0b, got %0b", want.empty, rsp_tuser[5]);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_frames();
      test_random_frames();
      test_back_to_back();
      test_top_bit_length();

      req_tvalid = 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (frame_results_due.size() != 0) begin
         $error("%0d expected transfers never arrived", frame_results_due.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

### websocket_frame_unmasker.f
sv/wfu_pkg.sv
sv/wfu_front.sv
sv/wfu_queue.sv
sv/wfu_back.sv
sv/websocket_frame_unmasker.sv
bench/tb_top.sv
